[rtl/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ax25fhv_pkg.sv]
// Types and constants for the AX.25 frame header validator
package ax25fhv_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned LEN_W    = 12;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INFO_LEN  = 1'd1;

    localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RST = 12'd330;
    localparam logic [LEN_W-1:0] MAX_INFO_LEN_RST  = 12'd256;

    localparam logic [COUNT_W-1:0] COUNT_SAT     = 13'd4096;
    localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 13'd15;

    localparam logic [SLOT_W-1:0] SSID_SLOT     = 3'd6;
    localparam logic [POS_W-1:0]  GROUP_LEN     = 7'd7;
    localparam logic [POS_W-1:0]  REPEATER_BASE = 7'd14;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_UPPER_Z = 7'h5a;
    localparam logic [6:0] CH_DIGIT_0 = 7'h30;
    localparam logic [6:0] CH_DIGIT_9 = 7'h39;

    localparam logic [DATA_W-1:0] SSID_H_BIT  = 8'h80;
    localparam logic [DATA_W-1:0] CTRL_PF_BIT = 8'h10;
    localparam logic [3:0]        CTRL_SREJ   = 4'hd;
    localparam logic [DATA_W-1:0] CTRL_UI     = 8'h03;
    localparam logic [DATA_W-1:0] CTRL_XID    = 8'haf;
    localparam logic [DATA_W-1:0] CTRL_TEST   = 8'he3;
    localparam logic [DATA_W-1:0] CTRL_SABM   = 8'h2f;
    localparam logic [DATA_W-1:0] CTRL_SABME  = 8'h6f;
    localparam logic [DATA_W-1:0] CTRL_DISC   = 8'h43;
    localparam logic [DATA_W-1:0] CTRL_UA     = 8'h63;
    localparam logic [DATA_W-1:0] CTRL_DM     = 8'h0f;
    localparam logic [DATA_W-1:0] PID_NO_L3   = 8'hf0;

    typedef struct packed {
        logic               addr_done;
        logic               addr_error;
        logic [POS_W-1:0]   ctrl_position;
        logic [DATA_W-1:0]  ctrl_byte;
        logic [DATA_W-1:0]  pid_byte;
        logic [COUNT_W-1:0] frame_len;
    } frame_status_t;

endpackage

[rtl/ax25_frame_header_validator.sv]
// Top level of the AX.25 frame header validator
//
//  Channel  Handshake             Payload
//  s_       s_valid / s_ready     s_data_byte, s_last_byte
//  m_       m_valid / m_ready     m_frame_ok, m_ui_frame, m_control_offset
//  cfg_     cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle unless a last byte waits on a stalled result: input register,
// one level of parse/classify logic, result register.
// Reset (synchronous, aresetn low) clears frame state and loads default limits.
// A stalled result blocks the next last byte and the bytes behind it; earlier bytes keep flowing.
module ax25_frame_header_validator
    import ax25fhv_pkg::*;
#(
    parameter int unsigned MAX_ADDRESSES = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [DATA_W-1:0]    s_data_byte,
    input  logic                 s_last_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_frame_ok,
    output logic                 m_ui_frame,
    output logic [POS_W-1:0]     m_control_offset,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    logic               in_valid_reg;
    logic [DATA_W-1:0]  in_data_reg;
    logic               in_last_reg;
    logic               out_valid_reg, out_valid_next;
    logic               frame_ok_reg;
    logic               ui_frame_reg;
    logic [POS_W-1:0]   control_offset_reg;
    logic [LEN_W-1:0]   max_frame_len_reg;
    logic [LEN_W-1:0]   max_info_len_reg;
    logic               step;
    logic               frame_ok;
    logic               ui_frame;
    logic [POS_W-1:0]   control_offset;
    frame_status_t      status;

    assign step           = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || step;
    assign cfg_ready      = 1'b1;
    assign out_valid_next = (out_valid_reg && !m_ready) || (step && in_last_reg);

    ax25fhv_track #(
        .MAX_ADDRESSES(MAX_ADDRESSES)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .status    (status)
    );

    ax25fhv_class u_class (
        .status         (status),
        .max_frame_len  (max_frame_len_reg),
        .max_info_len   (max_info_len_reg),
        .frame_ok       (frame_ok),
        .ui_frame       (ui_frame),
        .control_offset (control_offset)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            max_frame_len_reg <= MAX_FRAME_LEN_RST;
            max_info_len_reg  <= MAX_INFO_LEN_RST;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_data;
                    CFG_MAX_INFO_LEN:  max_info_len_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (step && in_last_reg) begin
            frame_ok_reg       <= frame_ok;
            ui_frame_reg       <= ui_frame;
            control_offset_reg <= control_offset;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_ok       = frame_ok_reg;
    assign m_ui_frame       = ui_frame_reg;
    assign m_control_offset = control_offset_reg;

endmodule

[rtl/ax25fhv_track.sv]
// Per-frame address field parser and control/PID capture
module ax25fhv_track
    import ax25fhv_pkg::*;
#(
    parameter int unsigned MAX_ADDRESSES = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [DATA_W-1:0]   data_byte,
    input  logic                last_byte,
    output frame_status_t       status
);

    localparam logic [POS_W-1:0] ADDR_LIMIT = POS_W'(7 * MAX_ADDRESSES);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [SLOT_W-1:0]  group_slot_reg, group_slot_next;
    logic [POS_W-1:0]   group_base_reg, group_base_next;
    logic               address_done_reg, address_done_next;
    logic               address_error_reg, address_error_next;
    logic               padding_seen_reg, padding_seen_next;
    logic               repeater_unused_reg, repeater_unused_next;
    logic [POS_W-1:0]   ctrl_position_reg, ctrl_position_next;
    logic [DATA_W-1:0]  ctrl_byte_reg, ctrl_byte_next;
    logic [DATA_W-1:0]  pid_byte_reg, pid_byte_next;
    logic [COUNT_W-1:0] frame_len;
    logic [COUNT_W-1:0] ctrl_pos_wide;
    logic [6:0]         ch;
    logic               ch_ok;
    logic               repeater_error;

    assign ch    = data_byte[7:1];
    assign ch_ok = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
                   (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9);
    assign ctrl_pos_wide = {{(COUNT_W-POS_W){1'b0}}, ctrl_position_reg};
    assign frame_len     = byte_count_reg + 13'd1;

    always_comb begin
        group_slot_next      = group_slot_reg;
        group_base_next      = group_base_reg;
        address_done_next    = address_done_reg;
        address_error_next   = address_error_reg;
        padding_seen_next    = padding_seen_reg;
        repeater_unused_next = repeater_unused_reg;
        ctrl_position_next   = ctrl_position_reg;
        ctrl_byte_next       = ctrl_byte_reg;
        pid_byte_next        = pid_byte_reg;
        repeater_error       = 1'b0;
        if (address_done_reg && !address_error_reg) begin
            if (byte_count_reg == ctrl_pos_wide) begin
                ctrl_byte_next = data_byte;
            end else if (byte_count_reg == ctrl_pos_wide + 13'd1) begin
                pid_byte_next = data_byte;
            end
        end else if (!address_error_reg) begin
            if (group_slot_reg < SSID_SLOT) begin
                if (data_byte[0]) begin
                    address_error_next = 1'b1;
                end else if (ch == CH_SPACE && group_slot_reg != '0) begin
                    padding_seen_next = 1'b1;
                end else if (padding_seen_reg || !ch_ok) begin
                    address_error_next = 1'b1;
                end
                group_slot_next = group_slot_reg + 3'd1;
            end else begin
                if (group_base_reg >= REPEATER_BASE) begin
                    if ((data_byte & SSID_H_BIT) == '0) begin
                        repeater_unused_next = 1'b1;
                    end else if (repeater_unused_reg) begin
                        repeater_error = 1'b1;
                    end
                end
                if (repeater_error) begin
                    address_error_next = 1'b1;
                end else if (data_byte[0]) begin
                    if (group_base_reg >= GROUP_LEN) begin
                        address_done_next  = 1'b1;
                        ctrl_position_next = group_base_reg + GROUP_LEN;
                    end else begin
                        address_error_next = 1'b1;
                    end
                end else begin
                    group_slot_next   = '0;
                    padding_seen_next = 1'b0;
                    group_base_next   = group_base_reg + GROUP_LEN;
                    if (group_base_next >= ADDR_LIMIT) begin
                        address_error_next = 1'b1;
                    end
                end
            end
        end
        byte_count_next = (byte_count_reg < COUNT_SAT) ? frame_len : byte_count_reg;
    end

    always_comb begin
        status.addr_done     = address_done_next;
        status.addr_error    = address_error_next;
        status.ctrl_position = ctrl_position_next;
        status.ctrl_byte     = ctrl_byte_next;
        status.pid_byte      = pid_byte_next;
        status.frame_len     = frame_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            byte_count_reg      <= '0;
            group_slot_reg      <= '0;
            group_base_reg      <= '0;
            address_done_reg    <= 1'b0;
            address_error_reg   <= 1'b0;
            padding_seen_reg    <= 1'b0;
            repeater_unused_reg <= 1'b0;
            ctrl_position_reg   <= '0;
            ctrl_byte_reg       <= '0;
            pid_byte_reg        <= '0;
        end else if (step) begin
            byte_count_reg      <= byte_count_next;
            group_slot_reg      <= group_slot_next;
            group_base_reg      <= group_base_next;
            address_done_reg    <= address_done_next;
            address_error_reg   <= address_error_next;
            padding_seen_reg    <= padding_seen_next;
            repeater_unused_reg <= repeater_unused_next;
            ctrl_position_reg   <= ctrl_position_next;
            ctrl_byte_reg       <= ctrl_byte_next;
            pid_byte_reg        <= pid_byte_next;
        end
    end

endmodule

[rtl/ax25fhv_class.sv]
// Control field classification and length checks for the frame verdict
module ax25fhv_class
    import ax25fhv_pkg::*;
(
    input  frame_status_t       status,
    input  logic [LEN_W-1:0]    max_frame_len,
    input  logic [LEN_W-1:0]    max_info_len,
    output logic                frame_ok,
    output logic                ui_frame,
    output logic [POS_W-1:0]    control_offset
);

    logic [COUNT_W-1:0] len;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] info1;
    logic [COUNT_W-1:0] info2;
    logic [COUNT_W-1:0] info_lim;
    logic [DATA_W-1:0]  ctrl;
    logic               addr_ok;
    logic               u_cmd_ok;
    logic               ok;

    assign len      = status.frame_len;
    assign pos      = {{(COUNT_W-POS_W){1'b0}}, status.ctrl_position};
    assign info1    = len - pos - 13'd1;
    assign info2    = len - pos - 13'd2;
    assign info_lim = {1'b0, max_info_len};
    assign ctrl     = status.ctrl_byte & ~CTRL_PF_BIT;

    assign addr_ok = status.addr_done && !status.addr_error && len >= MIN_FRAME_LEN &&
                     len <= {1'b0, max_frame_len} && pos < len;

    always_comb begin
        case (ctrl) inside
            CTRL_SABM, CTRL_SABME, CTRL_DISC, CTRL_UA, CTRL_DM: u_cmd_ok = 1'b1;
            default: u_cmd_ok = 1'b0;
        endcase
    end

    always_comb begin
        if (!ctrl[0] || ctrl == CTRL_UI) begin
            ok = (len >= pos + 13'd2) && (info2 <= info_lim);
        end else if (ctrl[1:0] == 2'b01) begin
            ok = (len == pos + 13'd1) && (ctrl[3:0] != CTRL_SREJ);
        end else if (ctrl == CTRL_XID || ctrl == CTRL_TEST) begin
            ok = info1 <= info_lim;
        end else begin
            ok = (len == pos + 13'd1) && u_cmd_ok;
        end
    end

    assign frame_ok       = addr_ok && ok;
    assign ui_frame       = addr_ok && (len >= pos + 13'd3) && (info2 <= info_lim) &&
                            status.ctrl_byte == CTRL_UI && status.pid_byte == PID_NO_L3;
    assign control_offset = addr_ok ? status.ctrl_position : '0;

endmodule

[rtl/ax25fhv_checker.sv]
// Port-level checker for the AX.25 frame header validator, with its bind
`include "assert_macros.svh"

module ax25fhv_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_frame_ok,
    input logic       m_ui_frame,
    input logic [6:0] m_control_offset
);

    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_frame_ok) && $stable(m_ui_frame) && $stable(m_control_offset), "stalled result transaction changed")
    `ASSERT_IMPLY(a_ui_is_ok, aclk, aresetn, m_valid && m_ui_frame, m_frame_ok, "UI frame reported but frame rejected")
    `ASSERT_IMPLY(a_ok_has_offset, aclk, aresetn, m_valid && m_frame_ok, m_control_offset != 7'd0, "accepted frame without control offset")
    `ASSERT_IMPLY(a_offset_range, aclk, aresetn, m_valid && m_control_offset != 7'd0, m_control_offset >= 7'd14 && m_control_offset <= 7'd70, "control offset out of range")

endmodule

bind ax25_frame_header_validator ax25fhv_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_frame_ok       (m_frame_ok),
    .m_ui_frame       (m_ui_frame),
    .m_control_offset (m_control_offset)
);
